@@ rtl/rfc_pkg.sv @@
// Shared constants, node word layout and arithmetic unit request type
// for the range flip / count segment tree. No dependencies.
package rfc_pkg;

  localparam int LEAVES = 1024;                  // power of two
  localparam int LOG    = $clog2(LEAVES);        // tree height
  localparam int AW     = LOG + 1;               // node address bits (heap, root at 1)
  localparam int DEPTH  = 1 << AW;
  localparam int PTR_W  = AW + 1;                // boundary pointers reach 2*LEAVES
  localparam int CNT_W  = LOG + 1;               // count of a full span
  localparam int WORD_W = CNT_W + 1;
  localparam int LVL_W  = $clog2(LOG + 2);
  localparam int POS_W  = 10;                    // range field width
  localparam int OUT_W  = 11;                    // ones_count width

  typedef enum logic {
    ACT_FLIP,   // invert bits in range
    ACT_COUNT   // count set bits in range
  } action_t;

  typedef struct packed {
    logic             lazy;   // children still owe a flip
    logic [CNT_W-1:0] cnt;    // ones in span, own flips applied
  } node_t;

  typedef enum logic {
    ALU_FLIP,   // b - a : span length minus count
    ALU_ADD     // a + b
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [CNT_W-1:0] a;
    logic [CNT_W-1:0] b;
  } alu_req_t;

endpackage

@@ rtl/rfc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/rfc_alu.sv @@
// Shared node arithmetic: span flip (length minus count) and count add.
// Depends on rfc_pkg.
module rfc_alu (
  input  rfc_pkg::alu_req_t             req,
  output logic [rfc_pkg::CNT_W-1:0]     res
);

  always_comb begin
    unique case (req.op)
      rfc_pkg::ALU_FLIP: res = req.b - req.a;
      rfc_pkg::ALU_ADD:  res = req.a + req.b;
      default:           res = '0;
    endcase
  end

endmodule

@@ rtl/range_flip_count_segment_tree.sv @@
// Top level: range flip / range count over a row of bits, lazy segment tree.
// Depends on rfc_pkg, rfc_ram, rfc_alu.
//
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    s_tuser = action, s_tdata = range_low, range_high
// m_*       out  m_tvalid/m_tready    m_tdata = ones_count (count transactions only)
//
// Operation: one transaction at a time through one node RAM port pair and one
// shared adder. Push-down visits both boundary paths over LOG levels, reading
// each misaligned node and pushing its flip to both children when it owes one.
// The cover loop then visits the canonical cover nodes level by level; a flip
// then rebuilds up to 2*LOG parents. An empty flip changes nothing; an empty
// count returns zero through the output register.
// Reset: synchronous; a clearing pass zeroes all 2048 words of the node RAM
// before s_tready rises. A count result waits in the output register; only the
// next count holds at its last step until that register is free.
module range_flip_count_segment_tree (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [9:0] range_low, [19:10] range_high, rest zero
  input  logic        s_tuser,   // [0] action: 0 flip, 1 count
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [10:0] ones_count, rest zero
);

  localparam int AW    = rfc_pkg::AW;
  localparam int PTR_W = rfc_pkg::PTR_W;
  localparam int CNT_W = rfc_pkg::CNT_W;
  localparam int LVL_W = rfc_pkg::LVL_W;
  localparam int POS_W = rfc_pkg::POS_W;
  localparam int OUT_W = rfc_pkg::OUT_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PUSH_SEL, S_P0, S_P1, S_P2, S_P3,
    S_LOOP, S_A0, S_A1, S_UPD_SEL, S_U0, S_U1, S_U2
  } state_t;

  state_t               state;
  logic [PTR_W-1:0]     lo_ptr, hi_ptr, l0, r0;
  logic [LVL_W-1:0]     lvl;
  logic                 side;
  logic [AW-1:0]        node;
  logic [CNT_W-1:0]     node_len;
  rfc_pkg::node_t       hold;
  logic                 is_count;
  logic [CNT_W-1:0]     sum;
  logic [OUT_W-1:0]     out_count;
  logic [AW-1:0]        clr_addr;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  rfc_pkg::node_t       ram_wdata, ram_rdata;
  rfc_pkg::alu_req_t    alu_req;
  logic [CNT_W-1:0]     alu_res;

  logic [POS_W-1:0]     in_lo, in_hi;
  logic [PTR_W-1:0]     lvl_mask;
  logic                 l_edge, r_edge;
  logic [AW-1:0]        child;
  logic                 res_load;

  assign in_lo    = s_tdata[POS_W-1:0];
  assign in_hi    = s_tdata[2*POS_W-1:POS_W];
  assign lvl_mask = ~({PTR_W{1'b1}} << lvl);
  assign l_edge   = (l0 & lvl_mask) != '0;       // boundary not aligned at this level
  assign r_edge   = (r0 & lvl_mask) != '0;
  assign child    = {node[AW-2:0], 1'b0};

  // count finished and the output register is free (or emptying this cycle)
  assign res_load = (state == S_LOOP) && !(lo_ptr < hi_ptr) && is_count &&
                    (!m_tvalid || m_tready);

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {{(16-OUT_W){1'b0}}, out_count};

  rfc_ram #(.WIDTH(rfc_pkg::WORD_W), .DEPTH(rfc_pkg::DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rfc_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // RAM port and shared unit steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = node;
    ram_wdata = '0;
    ram_raddr = node;
    alu_req   = '{op: rfc_pkg::ALU_FLIP, a: ram_rdata.cnt, b: node_len};
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      S_P1: begin
        // clear own mark, fetch left child
        ram_we    = ram_rdata.lazy;
        ram_wdata = '{lazy: 1'b0, cnt: ram_rdata.cnt};
        ram_raddr = child;
      end
      S_P2: begin
        ram_we    = 1'b1;
        ram_waddr = child;
        ram_wdata = '{lazy: ~ram_rdata.lazy, cnt: alu_res};
        ram_raddr = child | AW'(1);
      end
      S_P3: begin
        ram_we    = 1'b1;
        ram_waddr = child | AW'(1);
        ram_wdata = '{lazy: ~ram_rdata.lazy, cnt: alu_res};
      end
      S_A1: begin
        if (is_count) begin
          alu_req = '{op: rfc_pkg::ALU_ADD, a: sum, b: ram_rdata.cnt};
        end else begin
          ram_we    = 1'b1;
          ram_wdata = '{lazy: ~ram_rdata.lazy, cnt: alu_res};
        end
      end
      S_U0: ram_raddr = child;
      S_U1: ram_raddr = child | AW'(1);
      S_U2: begin
        alu_req   = '{op: rfc_pkg::ALU_ADD, a: hold.cnt, b: ram_rdata.cnt};
        ram_we    = 1'b1;
        ram_wdata = '{lazy: 1'b0, cnt: alu_res};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      m_tvalid  <= 1'b0;
      side      <= 1'b0;
      lvl       <= '0;
      is_count  <= 1'b0;
    end else begin
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == {AW{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            is_count <= (s_tuser == rfc_pkg::ACT_COUNT);
            sum      <= '0;
            if (in_lo > in_hi) begin
              // empty count: zero result through the output stage
              if (s_tuser == rfc_pkg::ACT_COUNT) begin
                lo_ptr <= '0;
                hi_ptr <= '0;
                state  <= S_LOOP;
              end
            end else begin
              lo_ptr <= PTR_W'(in_lo) + PTR_W'(rfc_pkg::LEAVES);
              hi_ptr <= PTR_W'(in_hi) + PTR_W'(rfc_pkg::LEAVES + 1);
              l0     <= PTR_W'(in_lo) + PTR_W'(rfc_pkg::LEAVES);
              r0     <= PTR_W'(in_hi) + PTR_W'(rfc_pkg::LEAVES + 1);
              lvl    <= LVL_W'(rfc_pkg::LOG);
              side   <= 1'b0;
              state  <= S_PUSH_SEL;
            end
          end
        end
        S_PUSH_SEL: begin
          // settle pending marks top-down along both boundary paths
          if (lvl == '0) begin
            side  <= 1'b0;
            state <= S_LOOP;
          end else begin
            node_len <= CNT_W'(1) << (lvl - LVL_W'(1));
            if (!side) begin
              side <= 1'b1;
              node <= AW'(l0 >> lvl);
              if (l_edge) state <= S_P0;
            end else begin
              side <= 1'b0;
              lvl  <= lvl - LVL_W'(1);
              node <= AW'((r0 - PTR_W'(1)) >> lvl);
              if (r_edge) state <= S_P0;
            end
          end
        end
        S_P0: state <= S_P1;
        S_P1: state <= ram_rdata.lazy ? S_P2 : S_PUSH_SEL;
        S_P2: state <= S_P3;
        S_P3: state <= S_PUSH_SEL;
        S_LOOP: begin
          // canonical cover of [l, r) bottom-up
          if (lo_ptr < hi_ptr) begin
            node_len <= CNT_W'(1) << lvl;
            if (!side) begin
              side <= 1'b1;
              if (lo_ptr[0]) begin
                node   <= AW'(lo_ptr);
                lo_ptr <= lo_ptr + PTR_W'(1);
                state  <= S_A0;
              end
            end else begin
              side   <= 1'b0;
              lvl    <= lvl + LVL_W'(1);
              lo_ptr <= lo_ptr >> 1;
              if (hi_ptr[0]) begin
                node   <= AW'(hi_ptr - PTR_W'(1));
                hi_ptr <= (hi_ptr - PTR_W'(1)) >> 1;
                state  <= S_A0;
              end else begin
                hi_ptr <= hi_ptr >> 1;
              end
            end
          end else if (is_count) begin
            // hold here while the previous result is still waiting
            if (res_load) begin
              out_count <= OUT_W'(sum);
              state     <= S_IDLE;
            end
          end else begin
            lvl   <= LVL_W'(1);
            side  <= 1'b0;
            state <= S_UPD_SEL;
          end
        end
        S_A0: state <= S_A1;
        S_A1: begin
          if (is_count) sum <= alu_res;
          state <= S_LOOP;
        end
        S_UPD_SEL: begin
          // rebuild parent counts bottom-up along both boundary paths
          if (lvl == LVL_W'(rfc_pkg::LOG + 1)) begin
            state <= S_IDLE;
          end else if (!side) begin
            side <= 1'b1;
            node <= AW'(l0 >> lvl);
            if (l_edge) state <= S_U0;
          end else begin
            side <= 1'b0;
            lvl  <= lvl + LVL_W'(1);
            node <= AW'((r0 - PTR_W'(1)) >> lvl);
            if (r_edge) state <= S_U0;
          end
        end
        S_U0: state <= S_U1;
        S_U1: begin
          hold  <= ram_rdata;
          state <= S_U2;
        end
        S_U2: state <= S_UPD_SEL;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
